FILE: src/steg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// steg_pkg
// Shared types, register codes and the sine table generator for the sine tone
// envelope generator.
// ----------------------------------------------------------------------------
package steg_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned VOL_W      = 25;
  localparam int unsigned CFGLEN_W   = 24;

  localparam logic [VOL_W-1:0] VOL_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LEVEL    = 3'd0,
    CFG_ATTACK_LENGTH  = 3'd1,
    CFG_ATTACK_STEP    = 3'd2,
    CFG_SUSTAIN_LENGTH = 3'd3,
    CFG_RELEASE_LENGTH = 3'd4,
    CFG_RELEASE_STEP   = 3'd5,
    CFG_SAMPLE_FORMAT  = 3'd6,
    CFG_CHANNEL_COUNT  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S32 = 2'd2
  } fmt_e;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Register reset values
  localparam logic [VOL_W-1:0]    RST_START_LEVEL    = 25'd13421773;
  localparam logic [CFGLEN_W-1:0] RST_ATTACK_LENGTH  = 24'd4800;
  localparam logic [VOL_W-1:0]    RST_ATTACK_STEP    = 25'd699;
  localparam logic [CFGLEN_W-1:0] RST_SUSTAIN_LENGTH = 24'd19200;
  localparam logic [CFGLEN_W-1:0] RST_RELEASE_LENGTH = 24'd72000;
  localparam logic [VOL_W-1:0]    RST_RELEASE_STEP   = 25'd186;
  localparam logic [1:0]          RST_SAMPLE_FORMAT  = 2'd1;
  localparam logic [3:0]          RST_CHANNEL_COUNT  = 4'd2;

  typedef struct packed {
    logic [VOL_W-1:0]    start_level;
    logic [CFGLEN_W-1:0] attack_length;
    logic [VOL_W-1:0]    attack_step;
    logic [CFGLEN_W-1:0] sustain_length;
    logic [CFGLEN_W-1:0] release_length;
    logic [VOL_W-1:0]    release_step;
    logic [1:0]          sample_format;
    logic [3:0]          channel_count;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] phase_step;
    logic [23:0] note_length;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic [2:0]         channel_index;
    logic               last_channel;
    logic               note_end;
  } out_item_t;

  // Sine table generation (elaboration only)
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

  // Sine of r/2^qbits quarter turns, scaled to 2^(amp_bits-1)-1
  function automatic logic [63:0] sine_quarter(input int unsigned r,
                                               input int unsigned qbits,
                                               input int unsigned amp_bits);
    logic [63:0] amp;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    amp = (64'd1 << (amp_bits - 1)) - 64'd1;
    if (r >= (32'd1 << qbits)) begin
      return amp;
    end
    x  = (64'(r) * HALF_PI_Q30) >> qbits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / 64'(TAYLOR_DIV[i]);
    end
    s = (x * t) >> 30;
    v = (s * amp + (64'd1 << 29)) >> 30;
    return (v > amp) ? amp : v;
  endfunction

endpackage
`default_nettype wire

FILE: src/steg_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// steg_sine_rom
// Quarter-wave sine table with quadrant folding: phase index in, magnitude
// and sign out.
// ----------------------------------------------------------------------------
module steg_sine_rom #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int SINE_AMP_BITS   = 16
) (
  input  wire logic [SINE_INDEX_BITS-1:0] phase_idx,
  output logic      [SINE_AMP_BITS-2:0]   mag,
  output logic                            neg
);
  import steg_pkg::*;

  localparam int QBITS = SINE_INDEX_BITS - 2;
  localparam int QN    = 1 << QBITS;
  localparam int MW    = SINE_AMP_BITS - 1;

  logic [MW-1:0]    rom [QN+1];
  logic [1:0]       quad;
  logic [QBITS-1:0] r;
  logic [QBITS:0]   rom_idx;

  for (genvar k = 0; k <= QN; k++) begin : g_rom
    localparam logic [63:0] ENTRY = sine_quarter(k, QBITS, SINE_AMP_BITS);
    assign rom[k] = ENTRY[MW-1:0];
  end

  assign quad    = phase_idx[SINE_INDEX_BITS-1 -: 2];
  assign r       = phase_idx[QBITS-1:0];
  // mirror the table on odd quadrants
  assign rom_idx = quad[0] ? ((QBITS+1)'(QN) - {1'b0, r}) : {1'b0, r};
  assign mag     = rom[rom_idx];
  assign neg     = quad[1];

endmodule
`default_nettype wire

FILE: src/steg_voice.sv
`default_nettype none
// ----------------------------------------------------------------------------
// steg_voice
// Note state: phase accumulator, envelope counters and volume. Registers the
// sine magnitude and volume of each active tick for the scaling stage.
// ----------------------------------------------------------------------------
module steg_voice #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int SINE_AMP_BITS   = 16,
  parameter int LENGTH_BITS     = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire steg_pkg::cfg_t            cfg,
  input  wire logic                      in_valid,
  input  wire steg_pkg::in_item_t        in_data,
  output logic                           in_stall,
  input  wire logic                      s2_ready,
  output logic                           s1_valid,
  output logic [SINE_AMP_BITS-2:0]       s1_mag,
  output logic                           s1_neg,
  output logic [steg_pkg::VOL_W-1:0]     s1_vol,
  output logic                           s1_end
);
  import steg_pkg::*;

  localparam int MW = SINE_AMP_BITS - 1;

  logic [31:0]            phase_r, phase_nxt;
  logic [31:0]            step_r, step_nxt;
  logic [VOL_W-1:0]       vol_r, vol_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [LENGTH_BITS-1:0] atk_r, atk_nxt;
  logic [LENGTH_BITS-1:0] sus_r, sus_nxt;
  logic [LENGTH_BITS-1:0] rel_r, rel_nxt;
  logic                   active_r, active_nxt;

  logic                   s1_v_r;
  logic [MW-1:0]          s1_mag_r;
  logic                   s1_neg_r;
  logic [VOL_W-1:0]       s1_vol_r;
  logic                   s1_end_r;

  logic                   in_acc;
  logic                   start_go;
  logic                   tick_go;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [VOL_W:0]         vol_up;
  logic [MW-1:0]          rom_mag;
  logic                   rom_neg;

  steg_sine_rom #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS),
    .SINE_AMP_BITS   (SINE_AMP_BITS)
  ) u_rom (
    .phase_idx (phase_r[31 -: SINE_INDEX_BITS]),
    .mag       (rom_mag),
    .neg       (rom_neg)
  );

  assign in_stall = s1_v_r && !s2_ready;
  assign in_acc   = in_valid && !in_stall;
  assign start_go = in_acc && (in_data.action == ACT_START);
  assign tick_go  = in_acc && (in_data.action == ACT_TICK) && active_r;
  assign rem_dec  = rem_r - LENGTH_BITS'(1);
  assign vol_up   = {1'b0, vol_r} + {1'b0, cfg.attack_step};

  always_comb begin
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    vol_nxt    = vol_r;
    rem_nxt    = rem_r;
    atk_nxt    = atk_r;
    sus_nxt    = sus_r;
    rel_nxt    = rel_r;
    active_nxt = active_r;
    if (start_go) begin
      step_nxt   = in_data.phase_step;
      rem_nxt    = LENGTH_BITS'(in_data.note_length);
      vol_nxt    = cfg.start_level;
      atk_nxt    = LENGTH_BITS'(cfg.attack_length);
      sus_nxt    = LENGTH_BITS'(cfg.sustain_length);
      rel_nxt    = LENGTH_BITS'(cfg.release_length);
      active_nxt = (LENGTH_BITS'(in_data.note_length) != '0);
    end else if (tick_go) begin
      phase_nxt = phase_r + step_r;
      if (atk_r != '0) begin
        vol_nxt = vol_up[VOL_W] ? VOL_MAX : vol_up[VOL_W-1:0];
        atk_nxt = atk_r - LENGTH_BITS'(1);
      end else if (sus_r != '0) begin
        sus_nxt = sus_r - LENGTH_BITS'(1);
      end else if (rel_r != '0) begin
        // clamp the fall at zero
        vol_nxt = (cfg.release_step > vol_r) ? '0 : (vol_r - cfg.release_step);
        rel_nxt = rel_r - LENGTH_BITS'(1);
      end
      rem_nxt    = rem_dec;
      active_nxt = (rem_dec != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      step_r   <= '0;
      vol_r    <= '0;
      rem_r    <= '0;
      atk_r    <= '0;
      sus_r    <= '0;
      rel_r    <= '0;
      active_r <= 1'b0;
      s1_v_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      step_r   <= step_nxt;
      vol_r    <= vol_nxt;
      rem_r    <= rem_nxt;
      atk_r    <= atk_nxt;
      sus_r    <= sus_nxt;
      rel_r    <= rel_nxt;
      active_r <= active_nxt;
      if (tick_go) begin
        s1_v_r <= 1'b1;
      end else if (s2_ready) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // Sample uses phase and volume from before this tick's update
  always_ff @(posedge clk) begin
    if (tick_go) begin
      s1_mag_r <= rom_mag;
      s1_neg_r <= rom_neg;
      s1_vol_r <= vol_r;
      s1_end_r <= (rem_dec == '0);
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_mag   = s1_mag_r;
  assign s1_neg   = s1_neg_r;
  assign s1_vol   = s1_vol_r;
  assign s1_end   = s1_end_r;

endmodule
`default_nettype wire

FILE: src/steg_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// steg_scale
// Multiplies sine magnitude by volume into a register, then converts the
// product to the selected sample format.
// ----------------------------------------------------------------------------
module steg_scale #(
  parameter int SINE_AMP_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [1:0]                 sample_format,
  input  wire logic                       s1_valid,
  input  wire logic [SINE_AMP_BITS-2:0]   s1_mag,
  input  wire logic                       s1_neg,
  input  wire logic [steg_pkg::VOL_W-1:0] s1_vol,
  input  wire logic                       s1_end,
  output logic                            s2_ready,
  input  wire logic                       s2_take,
  output logic                            s2_valid,
  output logic [31:0]                     s2_sample,
  output logic                            s2_end
);
  import steg_pkg::*;

  localparam int MW = SINE_AMP_BITS - 1;
  localparam int PW = MW + VOL_W;
  localparam int SH = MW + 24;

  logic          s2_v_r;
  logic [PW-1:0] p_r;
  logic          neg_r;
  logic          end_r;

  logic [PW+7:0]  q8;
  logic [PW+7:0]  base8;
  logic [PW+7:0]  u8_wide;
  logic [7:0]     u8_val;
  logic [PW+14:0] m16;
  logic [PW+30:0] m32;
  logic [31:0]    s16_val;
  logic [31:0]    s32_val;

  function automatic logic [31:0] sat_signed(input logic [32:0] m,
                                             input logic        n,
                                             input logic [32:0] pmax);
    logic [32:0] lim;
    lim = m;
    if (n) begin
      if (lim > pmax + 33'd1) begin
        lim = pmax + 33'd1;
      end
      return 32'd0 - lim[31:0];
    end
    return (lim > pmax) ? pmax[31:0] : lim[31:0];
  endfunction

  assign s2_ready = !s2_v_r || s2_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      p_r   <= PW'(s1_mag) * PW'(s1_vol);
      neg_r <= s1_neg;
      end_r <= s1_end;
    end
  end

  // uint8: floor(128 + 127*x), saturated
  assign q8    = {p_r, 7'b0} - (PW+8)'(p_r);
  assign base8 = (PW+8)'(128) << SH;
  always_comb begin
    if (neg_r) begin
      u8_wide = (q8 > base8) ? '0 : ((base8 - q8) >> SH);
    end else begin
      u8_wide = (base8 + q8) >> SH;
    end
    u8_val = (u8_wide > (PW+8)'(255)) ? 8'hFF : u8_wide[7:0];
  end

  // k = 2^n - 1 as shift and subtract, then drop the Q fraction
  assign m16     = ({p_r, 15'b0} - (PW+15)'(p_r)) >> SH;
  assign m32     = ({p_r, 31'b0} - (PW+31)'(p_r)) >> SH;
  assign s16_val = sat_signed(33'(m16), neg_r, 33'd32767);
  assign s32_val = sat_signed(33'(m32), neg_r, 33'd2147483647);

  always_comb begin
    case (sample_format)
      FMT_U8:  s2_sample = 32'(u8_val);
      FMT_S16: s2_sample = s16_val;
      FMT_S32: s2_sample = s32_val;
      default: s2_sample = '0;
    endcase
  end

  assign s2_valid = s2_v_r;
  assign s2_end   = end_r;

endmodule
`default_nettype wire

FILE: src/steg_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// steg_emit
// Output register: repeats each sample once per channel, marking the last
// copy.
// ----------------------------------------------------------------------------
module steg_emit #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [3:0]          channel_count,
  input  wire logic                s2_valid,
  input  wire logic [31:0]         s2_sample,
  input  wire logic                s2_end,
  output logic                     s2_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output steg_pkg::out_item_t      out_data
);
  import steg_pkg::*;

  localparam int NW = $clog2(MAX_CHANNELS + 1);
  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic          out_v_r;
  logic [31:0]   sample_r;
  logic [CW-1:0] ch_r;
  logic [NW-1:0] rem_r;
  logic          end_r;

  logic [NW-1:0] chans;
  logic          last;
  logic          out_acc;

  always_comb begin
    if (channel_count == 4'd0) begin
      chans = NW'(1);
    end else if (channel_count > 4'(MAX_CHANNELS)) begin
      chans = NW'(MAX_CHANNELS);
    end else begin
      chans = NW'(channel_count);
    end
  end

  assign last    = (rem_r == '0);
  assign out_acc = out_v_r && !out_stall;
  assign s2_take = !out_v_r || (out_acc && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_take) begin
      out_v_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      if (s2_valid) begin
        sample_r <= s2_sample;
        end_r    <= s2_end;
        ch_r     <= '0;
        rem_r    <= chans - NW'(1);
      end
    end else if (out_acc) begin
      // advance to the next channel copy
      ch_r  <= ch_r + CW'(1);
      rem_r <= rem_r - NW'(1);
    end
  end

  assign out_valid              = out_v_r;
  assign out_data.sample_value  = sample_r;
  assign out_data.channel_index = 3'(ch_r);
  assign out_data.last_channel  = last;
  assign out_data.note_end      = end_r;

endmodule
`default_nettype wire

FILE: src/sine_tone_envelope_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sine_tone_envelope_generator_top
// Sine tone oscillator with a linear attack/sustain/release envelope.
// ----------------------------------------------------------------------------
// Input beats carry an action: start a note (load phase step and length,
// restart the envelope) or tick one sample. Start beats and ticks with no
// active note are absorbed and give no output beat. A tick of an
// active note gives one output beat per channel (channel_count, clamped to
// 1..MAX_CHANNELS), all with the same sample, the last one flagged.
// The first copy of a tick passes the state/table stage, the multiply stage
// and the output register in turn before it shows on out_valid.
// Throughput: one input beat per cycle while the pipeline has room; the output
// register holds a tick until all its channel copies are taken, so a new tick
// enters it only after the last copy of the one before.
// Stall: out_stall holds the current beat; the two inner stages fill and
// then in_stall rises. Config writes (cfg_ready is always high) must only be
// made while the block is idle.
// Reset: synchronous, clears the note state, the phase and all valid flags
// and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module sine_tone_envelope_generator_top #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int SINE_AMP_BITS   = 16,
  parameter int MAX_CHANNELS    = 8,
  parameter int LENGTH_BITS     = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire steg_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output steg_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [steg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [steg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import steg_pkg::*;

  cfg_t cfg_r;

  logic                     s1_valid;
  logic [SINE_AMP_BITS-2:0] s1_mag;
  logic                     s1_neg;
  logic [VOL_W-1:0]         s1_vol;
  logic                     s1_end;
  logic                     s2_ready;
  logic                     s2_take;
  logic                     s2_valid;
  logic [31:0]              s2_sample;
  logic                     s2_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_level    <= RST_START_LEVEL;
      cfg_r.attack_length  <= RST_ATTACK_LENGTH;
      cfg_r.attack_step    <= RST_ATTACK_STEP;
      cfg_r.sustain_length <= RST_SUSTAIN_LENGTH;
      cfg_r.release_length <= RST_RELEASE_LENGTH;
      cfg_r.release_step   <= RST_RELEASE_STEP;
      cfg_r.sample_format  <= RST_SAMPLE_FORMAT;
      cfg_r.channel_count  <= RST_CHANNEL_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_LEVEL:    cfg_r.start_level    <= cfg_wdata[VOL_W-1:0];
        CFG_ATTACK_LENGTH:  cfg_r.attack_length  <= cfg_wdata[CFGLEN_W-1:0];
        CFG_ATTACK_STEP:    cfg_r.attack_step    <= cfg_wdata[VOL_W-1:0];
        CFG_SUSTAIN_LENGTH: cfg_r.sustain_length <= cfg_wdata[CFGLEN_W-1:0];
        CFG_RELEASE_LENGTH: cfg_r.release_length <= cfg_wdata[CFGLEN_W-1:0];
        CFG_RELEASE_STEP:   cfg_r.release_step   <= cfg_wdata[VOL_W-1:0];
        CFG_SAMPLE_FORMAT:  cfg_r.sample_format  <= cfg_wdata[1:0];
        CFG_CHANNEL_COUNT:  cfg_r.channel_count  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  steg_voice #(
    .SINE_INDEX_BITS (SINE_INDEX_BITS),
    .SINE_AMP_BITS   (SINE_AMP_BITS),
    .LENGTH_BITS     (LENGTH_BITS)
  ) u_voice (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .s2_ready (s2_ready),
    .s1_valid (s1_valid),
    .s1_mag   (s1_mag),
    .s1_neg   (s1_neg),
    .s1_vol   (s1_vol),
    .s1_end   (s1_end)
  );

  steg_scale #(
    .SINE_AMP_BITS (SINE_AMP_BITS)
  ) u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_format (cfg_r.sample_format),
    .s1_valid      (s1_valid),
    .s1_mag        (s1_mag),
    .s1_neg        (s1_neg),
    .s1_vol        (s1_vol),
    .s1_end        (s1_end),
    .s2_ready      (s2_ready),
    .s2_take       (s2_take),
    .s2_valid      (s2_valid),
    .s2_sample     (s2_sample),
    .s2_end        (s2_end)
  );

  steg_emit #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .channel_count (cfg_r.channel_count),
    .s2_valid      (s2_valid),
    .s2_sample     (s2_sample),
    .s2_end        (s2_end),
    .s2_take       (s2_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

FILE: src/steg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// steg_checker
// Port-level checks for the sine tone envelope generator, bound to the top.
// ----------------------------------------------------------------------------
module steg_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire steg_pkg::out_item_t             out_data
);
  import steg_pkg::*;

  logic copy_step;
  assign copy_step = out_valid && !out_stall && !out_data.last_channel;

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // copies of one tick follow on with the next channel
  a_chan_seq: assert property (@(posedge clk) disable iff (!rst_n)
    copy_step |=> out_valid &&
      out_data.channel_index == 3'($past(out_data.channel_index) + 3'd1))
    else $error("channel copies out of sequence");

  // all copies of one tick carry the same sample and end flag
  a_copy_same: assert property (@(posedge clk) disable iff (!rst_n)
    copy_step |=> out_data.sample_value == $past(out_data.sample_value) &&
      out_data.note_end == $past(out_data.note_end))
    else $error("channel copies differ");

  // an empty output register never backs up the input
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

endmodule

bind sine_tone_envelope_generator_top steg_checker u_checker (.*);
`default_nettype wire

FILE: bench/tone_sb_pkg.sv
// ----------------------------------------------------------------------------
// tone_sb_pkg
// Scoreboard for the sine tone envelope generator bench. It keeps its own
// phase, envelope and register state, renders the expected sample for every
// accepted tick and checks each output beat against the oldest expectation.
// ----------------------------------------------------------------------------
package tone_sb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import steg_pkg::*;

  localparam int unsigned QUARTER_BITS = 8;
  localparam int unsigned QUARTER_SIZE = 1 << QUARTER_BITS;
  localparam int unsigned SCALE_SHIFT  = 39;
  localparam int unsigned MAX_COPIES   = 8;
  localparam logic [63:0] WAVE_AMP     = 64'd32767;
  localparam logic [1:0]  FMT_UNUSED   = 2'd3;

  class tone_scoreboard;
    // register copy
    logic [VOL_W-1:0]    start_level;
    logic [CFGLEN_W-1:0] attack_length;
    logic [VOL_W-1:0]    attack_step;
    logic [CFGLEN_W-1:0] sustain_length;
    logic [CFGLEN_W-1:0] release_length;
    logic [VOL_W-1:0]    release_step;
    logic [1:0]          sample_format;
    logic [3:0]          channel_count;
    // note and envelope state
    logic [31:0]         phase_acc;
    logic [31:0]         note_step;
    logic [VOL_W-1:0]    volume;
    logic [23:0]         ticks_left;
    logic [23:0]         attack_left;
    logic [23:0]         sustain_left;
    logic [23:0]         release_left;
    bit                  note_on;
    logic [15:0]         quarter_wave [0:QUARTER_SIZE];
    out_item_t           expected_beats [$];
    int                  errors;

    function new();
      for (int unsigned r = 0; r <= QUARTER_SIZE; r++) begin
        quarter_wave[r] = 16'(quarter_sine(r));
      end
      start_level    = RST_START_LEVEL;
      attack_length  = RST_ATTACK_LENGTH;
      attack_step    = RST_ATTACK_STEP;
      sustain_length = RST_SUSTAIN_LENGTH;
      release_length = RST_RELEASE_LENGTH;
      release_step   = RST_RELEASE_STEP;
      sample_format  = RST_SAMPLE_FORMAT;
      channel_count  = RST_CHANNEL_COUNT;
      phase_acc      = '0;
      note_step      = '0;
      volume         = '0;
      ticks_left     = '0;
      attack_left    = '0;
      sustain_left   = '0;
      release_left   = '0;
      note_on        = 1'b0;
      errors         = 0;
    endfunction

    // Q30 Taylor series of sin over one quarter turn, rounded half up
    function logic [63:0] quarter_sine(int unsigned r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      int unsigned divs [6];
      divs = '{156, 110, 72, 42, 20, 6};
      if (r >= QUARTER_SIZE) begin
        return WAVE_AMP;
      end
      x  = (64'(r) * 64'd1686629713) >> QUARTER_BITS;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int i = 0; i < 6; i++) begin
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(divs[i]);
      end
      s = (x * t) >> 30;
      v = (s * WAVE_AMP + (64'd1 << 29)) >> 30;
      return (v > WAVE_AMP) ? WAVE_AMP : v;
    endfunction

    function logic [31:0] clip_signed(logic [95:0] m, logic neg, logic [95:0] top);
      if (neg) begin
        if (m > top + 96'd1) begin
          m = top + 96'd1;
        end
        return 32'd0 - m[31:0];
      end
      return (m > top) ? top[31:0] : m[31:0];
    endfunction

    function logic [31:0] render_sample();
      logic [9:0]  idx;
      logic        neg;
      logic [95:0] mag;
      logic [95:0] prod;
      logic [95:0] q;
      logic [95:0] base;
      logic [95:0] v;
      idx  = phase_acc[31:22];
      neg  = idx[9];
      mag  = idx[8] ? 96'(quarter_wave[QUARTER_SIZE - idx[7:0]]) :
                      96'(quarter_wave[idx[7:0]]);
      prod = mag * 96'(volume);
      case (sample_format)
        FMT_U8: begin
          base = 96'd128 << SCALE_SHIFT;
          q    = prod * 96'd127;
          if (neg) begin
            v = (q > base) ? 96'd0 : (base - q) >> SCALE_SHIFT;
          end else begin
            v = (base + q) >> SCALE_SHIFT;
          end
          return (v > 96'd255) ? 32'd255 : v[31:0];
        end
        FMT_S16: return clip_signed((prod * 96'd32767) >> SCALE_SHIFT, neg, 96'd32767);
        FMT_S32: begin
          return clip_signed((prod * 96'd2147483647) >> SCALE_SHIFT, neg,
                             96'd2147483647);
        end
        default: return 32'd0;
      endcase
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] d);
      case (idx)
        CFG_START_LEVEL:    start_level    = d[VOL_W-1:0];
        CFG_ATTACK_LENGTH:  attack_length  = d[CFGLEN_W-1:0];
        CFG_ATTACK_STEP:    attack_step    = d[VOL_W-1:0];
        CFG_SUSTAIN_LENGTH: sustain_length = d[CFGLEN_W-1:0];
        CFG_RELEASE_LENGTH: release_length = d[CFGLEN_W-1:0];
        CFG_RELEASE_STEP:   release_step   = d[VOL_W-1:0];
        CFG_SAMPLE_FORMAT:  sample_format  = d[1:0];
        CFG_CHANNEL_COUNT:  channel_count  = d[3:0];
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted input beat; returns the beats it queued
    function int take_item(in_item_t it);
      logic [31:0] sample;
      logic [25:0] sum;
      logic        last_tick;
      int          chans;
      int          c;
      out_item_t   beat;
      if (it.action == ACT_START) begin
        note_step    = it.phase_step;
        ticks_left   = it.note_length;
        volume       = start_level;
        attack_left  = attack_length;
        sustain_left = sustain_length;
        release_left = release_length;
        note_on      = (it.note_length != '0);
        return 0;
      end
      if (!note_on) begin
        return 0;
      end
      sample    = render_sample();
      phase_acc = phase_acc + note_step;
      if (attack_left != '0) begin
        sum         = {1'b0, volume} + {1'b0, attack_step};
        volume      = (sum > {1'b0, VOL_MAX}) ? VOL_MAX : sum[VOL_W-1:0];
        attack_left = attack_left - 24'd1;
      end else if (sustain_left != '0) begin
        sustain_left = sustain_left - 24'd1;
      end else if (release_left != '0) begin
        volume       = (release_step > volume) ? '0 : volume - release_step;
        release_left = release_left - 24'd1;
      end
      ticks_left = ticks_left - 24'd1;
      last_tick  = (ticks_left == '0);
      if (last_tick) begin
        note_on = 1'b0;
      end
      chans = (channel_count == 4'd0) ? 1 :
              (channel_count > 4'(MAX_COPIES)) ? MAX_COPIES : int'(channel_count);
      for (c = 0; c < chans; c++) begin
        beat.sample_value  = sample;
        beat.channel_index = 3'(c);
        beat.last_channel  = (c == chans - 1);
        beat.note_end      = last_tick;
        expected_beats.push_back(beat);
      end
      return chans;
    endfunction

    function void check_beat(out_item_t got);
      out_item_t exp;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat sample_value %0d channel_index %0d",
                 $time, got.sample_value, got.channel_index);
        errors++;
        return;
      end
      exp = expected_beats.pop_front();
      if (got.sample_value !== exp.sample_value) begin
        $display("%0t: sample_value expected %0d got %0d",
                 $time, exp.sample_value, got.sample_value);
        errors++;
      end
      if (got.channel_index !== exp.channel_index) begin
        $display("%0t: channel_index expected %0d got %0d",
                 $time, exp.channel_index, got.channel_index);
        errors++;
      end
      if (got.last_channel !== exp.last_channel) begin
        $display("%0t: last_channel expected %0b got %0b",
                 $time, exp.last_channel, got.last_channel);
        errors++;
      end
      if (got.note_end !== exp.note_end) begin
        $display("%0t: note_end expected %0b got %0b",
                 $time, exp.note_end, got.note_end);
        errors++;
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

FILE: bench/sine_tone_envelope_generator_top_tb.sv
// ----------------------------------------------------------------------------
// sine_tone_envelope_generator_top_tb
// Drives note starts and sample ticks through the tone generator under several
// register settings, with random gaps on both channels, a long output hold-off
// and a full drain, and checks every output beat against the scoreboard.
// ----------------------------------------------------------------------------
module sine_tone_envelope_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import steg_pkg::*;
  import tone_sb_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tone_scoreboard tone_sb;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             useful_items;
  bit             hold_request;
  int             hold_left;

  sine_tone_envelope_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when asked for one
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = 80;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tone_sb.check_beat(out_data);
    end
  end

  function automatic in_item_t note_item(logic act, logic [31:0] step, logic [23:0] len);
    in_item_t it;
    it.action      = act;
    it.phase_step  = step;
    it.note_length = len;
    return it;
  endfunction

  // Call at a falling edge; returns at a falling edge
  task automatic send_item(input in_item_t it);
    int n;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    n = tone_sb.take_item(it);
    if (it.action == ACT_START || n > 0) begin
      useful_items++;
    end
    @(negedge clk);
    // idle cycle by cycle at the sender's idle rate
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(note_item(ACT_TICK, $urandom, 24'($urandom)));
  endtask

  // Drop valid and wait for every expected beat; settle lets start beats clear
  task automatic wait_idle(input bit settle);
    in_valid <= 1'b0;
    while (tone_sb.pending() != 0) @(posedge clk);
    if (settle) begin
      repeat (8) @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic cfg_beat(input cfg_idx_e idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    tone_sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic program_regs(input cfg_t s);
    cfg_beat(CFG_START_LEVEL,    32'(s.start_level));
    cfg_beat(CFG_ATTACK_LENGTH,  32'(s.attack_length));
    cfg_beat(CFG_ATTACK_STEP,    32'(s.attack_step));
    cfg_beat(CFG_SUSTAIN_LENGTH, 32'(s.sustain_length));
    cfg_beat(CFG_RELEASE_LENGTH, 32'(s.release_length));
    cfg_beat(CFG_RELEASE_STEP,   32'(s.release_step));
    cfg_beat(CFG_SAMPLE_FORMAT,  32'(s.sample_format));
    cfg_beat(CFG_CHANNEL_COUNT,  32'(s.channel_count));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] short_or_wide_count();
    return ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
  endfunction

  function automatic logic [VOL_W-1:0] random_step();
    return ($urandom_range(2) == 0) ? VOL_W'($urandom) : VOL_W'($urandom_range(0, 'h400000));
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    case ($urandom_range(3))
      0:       s.start_level = '0;
      1:       s.start_level = 25'h1000000;
      2:       s.start_level = VOL_MAX;
      default: s.start_level = VOL_W'($urandom);
    endcase
    s.attack_length  = short_or_wide_count();
    s.attack_step    = random_step();
    s.sustain_length = short_or_wide_count();
    s.release_length = short_or_wide_count();
    s.release_step   = random_step();
    s.sample_format  = 2'($urandom_range(0, 3));
    s.channel_count  = 4'($urandom_range(0, 15));
    return s;
  endfunction

  // Mostly start-then-ticks sequences, some loose beats of either kind
  task automatic random_notes(input int budget, input bit pause_midway);
    int          target;
    bit          paused;
    logic [23:0] len;
    in_item_t    it;
    target = useful_items + budget;
    paused = 1'b0;
    while (useful_items < target) begin
      if (pause_midway && !paused && useful_items >= target - budget / 2) begin
        wait_idle(1'b0);
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(15))
          0:       len = '0;
          1, 2:    len = 24'($urandom);
          default: len = 24'($urandom_range(1, 12));
        endcase
        send_item(note_item(ACT_START, $urandom, len));
        send_ticks($urandom_range(1, 14));
      end else begin
        it.action      = 1'($urandom_range(1));
        it.phase_step  = $urandom;
        it.note_length = 24'($urandom);
        send_item(it);
      end
    end
  endtask

  initial begin
    tone_sb       = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    hold_request  = 1'b0;
    hold_left     = 0;
    useful_items  = 0;
    send_idle_pct = 29;
    recv_idle_pct = 62;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default registers: tick with no note, zero-length note, a short note
    // that walks three quadrants and runs out
    send_ticks(1);
    send_item(note_item(ACT_START, 32'h0, 24'h0));
    send_ticks(1);
    send_item(note_item(ACT_START, 32'h4000_0000, 24'd3));
    send_ticks(4);
    wait_idle(1'b1);

    // Full-scale volume with attack overflow, release underflow, envelope
    // done, then a restart during the note that keeps the phase
    program_regs(cfg_t'{start_level: VOL_MAX, attack_length: 24'd2, attack_step: VOL_MAX,
                        sustain_length: 24'd1, release_length: 24'd3,
                        release_step: VOL_MAX, sample_format: FMT_U8,
                        channel_count: 4'd8});
    send_item(note_item(ACT_START, 32'h0800_0000, 24'hFF_FFFF));
    send_ticks(7);
    send_item(note_item(ACT_START, 32'hFFFF_FFFF, 24'd2));
    send_ticks(3);
    wait_idle(1'b1);

    // Unused format code with a channel count of zero
    program_regs(cfg_t'{start_level: 25'h1000000, attack_length: 24'd0, attack_step: '0,
                        sustain_length: 24'd0, release_length: 24'hFF_FFFF,
                        release_step: 25'd1, sample_format: FMT_UNUSED,
                        channel_count: 4'd0});
    send_item(note_item(ACT_START, 32'h1234_5678, 24'd1));
    send_ticks(1);
    wait_idle(1'b1);

    // 32-bit samples, channel count above the maximum
    program_regs(cfg_t'{start_level: 25'h1000000, attack_length: 24'hFF_FFFF,
                        attack_step: 25'd1, sustain_length: 24'hFF_FFFF,
                        release_length: 24'hFF_FFFF, release_step: '0,
                        sample_format: FMT_S32, channel_count: 4'd15});
    send_item(note_item(ACT_START, 32'hC000_0000, 24'd2));
    send_ticks(2);
    wait_idle(1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_regs(random_setting());
      // hold the output long enough for the pipeline to back up into in_stall
      if (ph == 4) begin
        hold_request = 1'b1;
      end
      random_notes(10, ph == 2);
      wait_idle(1'b1);
    end

    if (tone_sb.errors == 0 && tone_sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
